// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sopf block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle as its antecedent
`define DPFS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define DPFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dpfs_pkg.sv
// ----------------------------------------------------------------------------
// dpfs_pkg
// Types shared between the sopf controller and its divider.
// ----------------------------------------------------------------------------
package dpfs_pkg;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } dpfs_div_status_type;

endpackage

// File: rtl/dpfs_divider.sv
// ----------------------------------------------------------------------------
// dpfs_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dpfs_divider import dpfs_pkg::*; #(
   parameter int W  = 16,
   parameter int DW = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [W-1:0]        dividend,
   input  logic [DW-1:0]       divisor,
   output dpfs_div_status_type status,
   output logic [W-1:0]        quotient,
   output logic [W-1:0]        remainder
);

   localparam int CNT_BITS = $clog2(W);

   typedef enum logic {
      S_IDLE,
      S_RUN
   } state_type;

   state_type            state_ff, state_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]         quo_ff, quo_in;
   logic [W-1:0]         rem_ff, rem_in;
   logic [DW-1:0]        dvs_ff, dvs_in;

   logic [W:0]           partial;
   logic [W:0]           dvs_ext;
   logic [W:0]           diff;
   logic                 fits;

   always_comb begin
      partial = {rem_ff, quo_ff[W-1]};
      dvs_ext = (W+1)'(dvs_ff);
      diff    = partial - dvs_ext;
      fits    = (partial >= dvs_ext);

      state_in = state_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               quo_in   = dividend;
               rem_in   = '0;
               dvs_in   = divisor;
               cnt_in   = CNT_BITS'(W - 1);
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            // shift next dividend bit in, subtract when it fits
            rem_in = fits ? diff[W-1:0] : partial[W-1:0];
            quo_in = {quo_ff[W-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = (state_ff == S_RUN);
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// File: rtl/distinct_prime_factor_sum.sv
// ----------------------------------------------------------------------------
// distinct_prime_factor_sum
// Sum of the distinct prime factors of a word, plus one, by trial division.
// ----------------------------------------------------------------------------
// Each request word carries one unsigned value; the block answers with one
// response word holding the sum of its distinct prime factors plus one (0 and
// 1 give value plus one). It works on one word at a time: req_tready is high
// only while the sequencer is idle, though a finished response may still be
// waiting on rsp_tready then. Each trial divisor d passes through square,
// compare and start, then one pass of the shared bit-serial divider, which
// then hands back its result; each exact division by a found factor makes
// a further pass through start and the divider. Up to about
// 2^(VALUE_BITS/2) divisors are tried, and 0 or 1 go straight from idle to
// finish.
`include "assert_macros.svh"

module distinct_prime_factor_sum import dpfs_pkg::*; #(
   parameter int VALUE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [VALUE_BITS-1:0] value, rest zero
   input  logic [((VALUE_BITS+7)/8)*8-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [VALUE_BITS:0] factor_sum_plus_one, rest zero
   output logic [((VALUE_BITS+8)/8)*8-1:0]       rsp_tdata
);

   localparam int RSP_BITS    = VALUE_BITS + 1;
   localparam int RSP_TDATA_W = ((VALUE_BITS + 8) / 8) * 8;
   localparam int D_BITS      = (VALUE_BITS + 1) / 2 + 1;
   localparam int SQ_BITS     = 2 * D_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_COMPARE,
      S_DIV_START,
      S_DIV_WAIT,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic [D_BITS-1:0]     d_ff, d_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic [RSP_BITS-1:0]   total_ff, total_in;
   logic                  added_ff, added_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic [VALUE_BITS-1:0] req_value;
   logic                  div_start;
   dpfs_div_status_type   div_status;
   logic [VALUE_BITS-1:0] div_quo;
   logic [VALUE_BITS-1:0] div_rem;
   logic [RSP_BITS-1:0]   tail;

   assign req_value = req_tdata[VALUE_BITS-1:0];
   assign div_start = (state_ff == S_DIV_START);

   dpfs_divider #(
      .W  (VALUE_BITS),
      .DW (D_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .status    (div_status),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      total_in     = total_ff;
      added_in     = added_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      // leftover cofactor above one is itself prime
      tail         = (n_ff > VALUE_BITS'(1)) ? RSP_BITS'(n_ff) : '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               d_in     = D_BITS'(2);
               added_in = 1'b0;
               if (req_value < VALUE_BITS'(2)) begin
                  // no prime factors: answer is value plus one
                  total_in = RSP_BITS'(req_value);
                  n_in     = '0;
                  state_in = S_FINISH;
               end else begin
                  total_in = '0;
                  n_in     = req_value;
                  state_in = S_SQUARE;
               end
            end
         end
         S_SQUARE: begin
            sq_in    = SQ_BITS'(d_ff) * SQ_BITS'(d_ff);
            state_in = S_COMPARE;
         end
         S_COMPARE: begin
            state_in = (sq_ff <= SQ_BITS'(n_ff)) ? S_DIV_START : S_FINISH;
         end
         S_DIV_START: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_status.done) begin
               if (div_rem == '0) begin
                  if (!added_ff) begin
                     total_in = total_ff + RSP_BITS'(d_ff);
                     added_in = 1'b1;
                  end
                  n_in     = div_quo;
                  state_in = S_DIV_START;
               end else begin
                  d_in     = d_ff + 1'b1;
                  added_in = 1'b0;
                  state_in = S_SQUARE;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = total_ff + tail + RSP_BITS'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      total_ff    <= total_in;
      added_ff    <= added_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   `DPFS_ASSERT(a_start_when_free, clock, reset, div_start |-> !div_status.busy, "divider restarted while busy")
   `DPFS_ASSERT(a_ready_div_idle, clock, reset, req_tready |-> !div_status.busy, "ready while divider busy")
   `DPFS_ASSERT(a_rsp_nonzero, clock, reset, rsp_valid_ff |-> (rsp_data_ff != '0), "response word is zero")
   `DPFS_ASSERT(a_divisor_min, clock, reset, div_start |-> (d_ff > D_BITS'(1)), "trial divisor below two")
   `DPFS_ASSERT_NEXT(a_done_pulse, clock, reset, div_status.done, !div_status.done, "divider done held")

endmodule

// File: tb/sv/sopf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sopf_checker
// Watches both streams of the sopf block, predicts and compares each sum.
// ----------------------------------------------------------------------------
// Every accepted request word is factored here by trial division. The
// expected sum is queued. Each accepted response word is checked against
// the oldest queued sum.
module sopf_checker #(
   parameter int VALUE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   // [VALUE_BITS-1:0] value, rest zero
   input  logic [((VALUE_BITS+7)/8)*8-1:0]       req_tdata,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [VALUE_BITS:0] factor_sum_plus_one, rest zero
   input  logic [((VALUE_BITS+8)/8)*8-1:0]       rsp_tdata,
   output int                                    fail_count,
   output int                                    words_in,
   output int                                    words_out,
   output int                                    sums_pending
);

   logic [VALUE_BITS:0] expected_sums[$];

   // distinct prime factors summed once each, plus one; 0 and 1 give value + 1
   function automatic logic [VALUE_BITS:0] sopf_plus_one(logic [VALUE_BITS-1:0] value);
      longint unsigned n;
      longint unsigned d;
      longint unsigned total;
      n = 64'(value);
      if (n < 2)
         return (VALUE_BITS+1)'(n + 1);
      total = 0;
      d = 2;
      while (d * d <= n) begin
         if (n % d == 0) begin
            total += d;
            while (n % d == 0)
               n = n / d;
         end
         d++;
      end
      // whatever is left is a prime above the square root
      if (n > 1)
         total += n;
      return (VALUE_BITS+1)'(total + 1);
   endfunction

   always @(posedge clock) begin
      logic [VALUE_BITS:0] expected_sum;
      logic [VALUE_BITS:0] actual_sum;
      if (reset) begin
         expected_sums.delete();
         fail_count   = 0;
         words_in     = 0;
         words_out    = 0;
         sums_pending = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_sums.push_back(sopf_plus_one(req_tdata[VALUE_BITS-1:0]));
            words_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            words_out++;
            actual_sum = rsp_tdata[VALUE_BITS:0];
            if (expected_sums.size() == 0) begin
               $error("factor_sum_plus_one: no word expected, actual %0d", actual_sum);
               fail_count++;
            end else begin
               expected_sum = expected_sums.pop_front();
               if (actual_sum !== expected_sum) begin
                  $error("factor_sum_plus_one: expected %0d, actual %0d",
                         expected_sum, actual_sum);
                  fail_count++;
               end
            end
         end
         sums_pending = expected_sums.size();
      end
   end

endmodule

// File: tb/sv/distinct_prime_factor_sum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_prime_factor_sum_tb
// Stimulus and verdict for the sopf block.
// ----------------------------------------------------------------------------
// Drives a directed set of values (zero, one, primes, prime powers, the
// extremes) and then random values, with random gaps on the request side and
// random stalls on the response side, including one long response hold-off.
// Prediction and comparison sit in sopf_checker.
module distinct_prime_factor_sum_tb;

   localparam int VALUE_BITS     = 16;
   localparam int REQ_BITS       = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_BITS       = ((VALUE_BITS + 8) / 8) * 8;
   localparam int RANDOM_WORDS   = 125;
   localparam int HOLD_OFF       = 15000;
   // covers the worst single word and the hold-off, plus margin
   localparam int WATCHDOG_LIMIT = 60000;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;

   int fail_count;
   int words_in;
   int words_out;
   int sums_pending;
   int idle_cycles;

   distinct_prime_factor_sum #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sopf_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .words_in     (words_in),
      .words_out    (words_out),
      .sums_pending (sums_pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return 0;
      else if (pick < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(20, 200);
   endfunction

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= REQ_BITS'(value);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_sums();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sums_pending != 0)
         @(negedge clock);
   endtask

   function automatic logic [VALUE_BITS-1:0] random_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         return VALUE_BITS'($urandom_range(0, 65535));
      else if (pick < 60)
         return VALUE_BITS'($urandom_range(0, 63));
      else if (pick < 80)
         return VALUE_BITS'($urandom_range(60000, 65535));
      else
         // small factor times a power of two: repeated factors
         return VALUE_BITS'((1 << $urandom_range(0, 8)) * $urandom_range(1, 255));
   endfunction

   // stimulus and verdict
   initial begin
      logic [VALUE_BITS-1:0] directed_values[$];
      directed_values = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd8, 16'd12,
                          16'd30030, 16'd32768, 16'd65025, 16'd63001, 16'd65521,
                          16'd65534, 16'd65535, 16'h5555, 16'hAAAA, 16'd1, 16'd0};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      foreach (directed_values[i])
         send_value(directed_values[i]);
      drain_sums();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         send_value(random_value());
         if (i == RANDOM_WORDS / 2)
            drain_sums();
      end
      drain_sums();
      repeat (50) @(negedge clock);

      $display("Sent %0d words and checked %0d sums: zero, one, primes, prime powers,",
               words_in, words_out);
      $display("16-bit extremes, random values, random gaps and a long response hold-off.");
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // response side: random stalls, quiet stretches, one long hold-off
   initial begin
      int  stall_left;
      int  quiet_left;
      bit  hold_done;
      stall_left = 0;
      quiet_left = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      while (reset)
         @(negedge clock);
      forever begin
         if (!hold_done && words_in >= 40) begin
            hold_done  = 1'b1;
            stall_left = HOLD_OFF;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (quiet_left > 0)
               quiet_left--;
            else if ($urandom_range(0, 199) == 0)
               quiet_left = $urandom_range(200, 2000);
            else if ($urandom_range(0, 7) == 0)
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 400)
                                                        : $urandom_range(1, 4);
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/dpfs_pkg.sv
rtl/dpfs_divider.sv
rtl/distinct_prime_factor_sum.sv
tb/sv/sopf_checker.sv
tb/sv/distinct_prime_factor_sum_tb.sv
